// File: rtl/core/kpcp_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the keypad PIN command parser.
// Used by the top level and by its port checker; depends on nothing.
package kpcp_pkg;

  typedef logic [3:0] key_t;
  typedef logic [3:0] outcome_t;
  typedef logic [1:0] op_t;
  typedef logic [7:0] mode_t;

  // Operation codes.
  localparam op_t OP_KEY         = 2'd0;
  localparam op_t OP_REMOTE_SET  = 2'd1;
  localparam op_t OP_REMOTE_CONF = 2'd2;

  // Key codes; every code below KEY_STAR is a digit.
  localparam key_t KEY_STAR = 4'd10;
  localparam key_t KEY_HASH = 4'd11;
  localparam key_t KEY_NONE = 4'd0;

  // Result outcomes.
  localparam outcome_t OC_BUFFERED    = 4'd0;
  localparam outcome_t OC_WRONG_PIN   = 4'd1;
  localparam outcome_t OC_MODE_SET    = 4'd2;
  localparam outcome_t OC_INVALID     = 4'd3;
  localparam outcome_t OC_INFO        = 4'd4;
  localparam outcome_t OC_REBOOT      = 4'd5;
  localparam outcome_t OC_EGG         = 4'd6;
  localparam outcome_t OC_PIN_CHANGED = 4'd7;
  localparam outcome_t OC_FORMAT      = 4'd8;
  localparam outcome_t OC_REMOTE_SET  = 4'd9;
  localparam outcome_t OC_REMOTE_CONF = 4'd10;

  // Command numbers entered after the first star.
  localparam int CMD_MODE_0     = 0;
  localparam int CMD_MODE_1     = 1;
  localparam int CMD_MODE_2     = 2;
  localparam int CMD_MODE_3     = 3;
  localparam int CMD_MODE_8     = 8;
  localparam int CMD_STATUS     = 77;
  localparam int CMD_RESTART    = 88;
  localparam int CMD_PIN_CHANGE = 99;
  localparam int CMD_EGG        = 1990;

  // Highest mode number that the keypad itself can select.
  localparam mode_t MODE_KEYPAD_MAX = 8'd8;

  // Length of the PIN after reset; the PIN is all zero digits.
  localparam int PIN_RESET_LENGTH = 4;

endpackage

// File: rtl/core/keypad_pin_command_parser.sv
`timescale 1ns / 1ps
// Top level of the keypad PIN command parser: key buffer, PIN store and alarm mode.
// Depends on kpcp_pkg.
//
// Every item (a key press or a remote mode operation) gives exactly one result. Key
// presses other than hash and both remote operations finish without a memory walk: the result
// is offered in the cycle after the transfer, and a new item may be taken in the same
// cycle as the previous result leaves. A hash walks the key buffer memory one entry a
// cycle through a registered read port, and the walk stops as soon as the outcome is
// known; a hash after a key was dropped at a full buffer answers at once. There is no
// clearing pass after reset: unwritten PIN entries read as zero through a valid bit
// per entry.
module keypad_pin_command_parser #(
  parameter int MAX_KEYS       = 16,
  parameter int MAX_CMD_DIGITS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  kpcp_pkg::op_t       op,
  input  kpcp_pkg::key_t      key_code,
  input  kpcp_pkg::mode_t     mode_value,
  output logic                result_valid,
  input  logic                result_ready,
  output kpcp_pkg::key_t      echo_code,
  output logic                echo_valid,
  output kpcp_pkg::outcome_t  outcome,
  output kpcp_pkg::mode_t     alarm_mode,
  output logic                acknowledged,
  output logic                notify_remote
);

  function automatic int pow10(input int n);
    int r;
    r = 1;
    for (int k = 0; k < n; k++) r = r * 10;
    return r;
  endfunction

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int VW = $clog2(pow10(MAX_CMD_DIGITS));
  localparam int DW = $clog2(MAX_CMD_DIGITS + 2);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  localparam logic [1:0] PH_PIN  = 2'd0;
  localparam logic [1:0] PH_NUM  = 2'd1;
  localparam logic [1:0] PH_SEEK = 2'd2;
  localparam logic [1:0] PH_COPY = 2'd3;

  // Storage.
  kpcp_pkg::key_t key_mem [MAX_KEYS];
  kpcp_pkg::key_t pin_mem [MAX_KEYS];
  logic [MAX_KEYS-1:0] pin_written;

  // Control and datapath registers.
  logic           state, state_next;
  logic [1:0]     phase, phase_next;
  logic [CW-1:0]  rd_idx, rd_idx_next;
  logic [CW-1:0]  proc_idx, proc_idx_next;
  logic           st_vld, st_vld_next;
  logic [CW-1:0]  key_count, key_count_next;
  logic           overflow, overflow_next;
  logic [CW-1:0]  pin_length, pin_length_next;
  kpcp_pkg::mode_t mode_reg, mode_reg_next;
  logic           ack_flag, ack_flag_next;
  logic           mask_echo, mask_echo_next;
  logic           mism, mism_next;
  logic [VW-1:0]  value, value_next;
  logic [DW-1:0]  ndig, ndig_next;
  logic [CW-1:0]  wcnt, wcnt_next;
  logic           result_valid_next;
  kpcp_pkg::key_t echo_code_next;
  logic           echo_valid_next;
  kpcp_pkg::outcome_t outcome_next;
  logic           notify_next;

  // Memory read data.
  kpcp_pkg::key_t key_q;
  kpcp_pkg::key_t pin_q;
  logic           pin_ok_q;

  logic           item_fire;
  logic           key_we;
  logic           pin_we;
  logic           load;
  logic [AW-1:0]  rd_addr;
  kpcp_pkg::key_t pin_eff;
  logic           at_end;
  logic           is_digit;
  logic           done;

  assign item_ready = (state == S_IDLE) && (!result_valid || result_ready);
  assign item_fire  = item_valid && item_ready;
  assign rd_addr    = (rd_idx < CW'(MAX_KEYS)) ? rd_idx[AW-1:0] : '0;
  assign pin_eff    = pin_ok_q ? pin_q : kpcp_pkg::KEY_NONE;
  assign at_end     = (proc_idx == key_count);
  assign is_digit   = (key_q < kpcp_pkg::KEY_STAR);

  always_comb begin
    state_next        = state;
    phase_next        = phase;
    rd_idx_next       = rd_idx;
    proc_idx_next     = proc_idx;
    st_vld_next       = st_vld;
    key_count_next    = key_count;
    overflow_next     = overflow;
    pin_length_next   = pin_length;
    mode_reg_next     = mode_reg;
    ack_flag_next     = ack_flag;
    mask_echo_next    = mask_echo;
    mism_next         = mism;
    value_next        = value;
    ndig_next         = ndig;
    wcnt_next         = wcnt;
    result_valid_next = result_valid && !result_ready;
    echo_code_next    = echo_code;
    echo_valid_next   = echo_valid;
    outcome_next      = outcome;
    notify_next       = notify_remote;
    key_we            = 1'b0;
    pin_we            = 1'b0;
    load              = 1'b0;
    done              = 1'b0;

    if (item_fire) begin
      echo_code_next  = kpcp_pkg::KEY_NONE;
      echo_valid_next = 1'b0;
      notify_next     = 1'b0;
      unique case (op)
        kpcp_pkg::OP_KEY: begin
          echo_code_next  = mask_echo ? kpcp_pkg::KEY_STAR : key_code;
          echo_valid_next = 1'b1;
          if (key_code == kpcp_pkg::KEY_STAR) begin
            mask_echo_next = 1'b0;
          end
          if (key_code == kpcp_pkg::KEY_HASH) begin
            if (overflow) begin
              load         = 1'b1;
              done         = 1'b1;
              outcome_next = kpcp_pkg::OC_FORMAT;
            end else begin
              state_next  = S_SCAN;
              phase_next  = PH_PIN;
              rd_idx_next = '0;
              st_vld_next = 1'b0;
              mism_next   = 1'b0;
              value_next  = '0;
              ndig_next   = '0;
              wcnt_next   = '0;
            end
          end else begin
            load         = 1'b1;
            outcome_next = kpcp_pkg::OC_BUFFERED;
            if (key_count < CW'(MAX_KEYS)) begin
              key_we         = 1'b1;
              key_count_next = key_count + 1'b1;
            end else begin
              overflow_next = 1'b1;
            end
          end
        end
        kpcp_pkg::OP_REMOTE_SET: begin
          load          = 1'b1;
          mode_reg_next = mode_value;
          notify_next   = 1'b1;
          outcome_next  = kpcp_pkg::OC_REMOTE_SET;
        end
        kpcp_pkg::OP_REMOTE_CONF: begin
          load          = 1'b1;
          mode_reg_next = mode_value;
          ack_flag_next = 1'b1;
          outcome_next  = kpcp_pkg::OC_REMOTE_CONF;
        end
        default: begin
          load         = 1'b1;
          outcome_next = kpcp_pkg::OC_INVALID;
        end
      endcase
    end else if (state == S_SCAN) begin
      // Reads stream one entry a cycle; the stage below sees the entry read last cycle.
      st_vld_next   = 1'b1;
      proc_idx_next = rd_idx;
      rd_idx_next   = (rd_idx == key_count) ? rd_idx : rd_idx + 1'b1;
      if (st_vld) begin
        unique case (phase)
          PH_PIN: begin
            if (at_end || key_q == kpcp_pkg::KEY_STAR) begin
              if (proc_idx == pin_length && !mism) begin
                if (at_end) begin
                  // No star at all: the command number is zero.
                  done          = 1'b1;
                  outcome_next  = kpcp_pkg::OC_MODE_SET;
                  mode_reg_next = '0;
                  ack_flag_next = 1'b0;
                  notify_next   = 1'b1;
                end else begin
                  phase_next = PH_NUM;
                end
              end else begin
                done         = 1'b1;
                outcome_next = kpcp_pkg::OC_WRONG_PIN;
              end
            end else if (key_q != pin_eff) begin
              mism_next = 1'b1;
            end
          end
          PH_NUM: begin
            if (at_end || !is_digit) begin
              done = 1'b1;
              if (ndig > DW'(MAX_CMD_DIGITS)) begin
                outcome_next = kpcp_pkg::OC_INVALID;
              end else begin
                case (value)
                  VW'(kpcp_pkg::CMD_MODE_0), VW'(kpcp_pkg::CMD_MODE_1),
                  VW'(kpcp_pkg::CMD_MODE_2), VW'(kpcp_pkg::CMD_MODE_3),
                  VW'(kpcp_pkg::CMD_MODE_8): begin
                    outcome_next  = kpcp_pkg::OC_MODE_SET;
                    mode_reg_next = value[7:0];
                    ack_flag_next = 1'b0;
                    notify_next   = 1'b1;
                  end
                  VW'(kpcp_pkg::CMD_STATUS):  outcome_next = kpcp_pkg::OC_INFO;
                  VW'(kpcp_pkg::CMD_RESTART): outcome_next = kpcp_pkg::OC_REBOOT;
                  VW'(kpcp_pkg::CMD_EGG):     outcome_next = kpcp_pkg::OC_EGG;
                  VW'(kpcp_pkg::CMD_PIN_CHANGE): begin
                    if (at_end) begin
                      outcome_next = kpcp_pkg::OC_FORMAT;
                    end else begin
                      // The key that ended the number may already be the second star.
                      done       = 1'b0;
                      phase_next = (key_q == kpcp_pkg::KEY_STAR) ? PH_COPY : PH_SEEK;
                    end
                  end
                  default: outcome_next = kpcp_pkg::OC_INVALID;
                endcase
              end
            end else begin
              if (ndig < DW'(MAX_CMD_DIGITS)) begin
                value_next = VW'(({4'd0, value} << 3) + ({4'd0, value} << 1)
                                 + (VW + 4)'(key_q));
              end
              if (ndig <= DW'(MAX_CMD_DIGITS)) begin
                ndig_next = ndig + 1'b1;
              end
            end
          end
          PH_SEEK: begin
            if (at_end) begin
              done         = 1'b1;
              outcome_next = kpcp_pkg::OC_FORMAT;
            end else if (key_q == kpcp_pkg::KEY_STAR) begin
              phase_next = PH_COPY;
            end
          end
          PH_COPY: begin
            if (at_end) begin
              done            = 1'b1;
              outcome_next    = kpcp_pkg::OC_PIN_CHANGED;
              pin_length_next = wcnt;
            end else begin
              pin_we    = 1'b1;
              wcnt_next = wcnt + 1'b1;
            end
          end
          default: begin
            phase_next = PH_PIN;
          end
        endcase
        if (done) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
    end

    // A finished entry clears the buffer and masks the echo again.
    if (done) begin
      key_count_next = '0;
      overflow_next  = 1'b0;
      mask_echo_next = 1'b1;
    end

    if (load) begin
      result_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_count[AW-1:0]] <= key_code;
    end
    if (pin_we) begin
      pin_mem[wcnt[AW-1:0]] <= key_q;
    end
    key_q    <= key_mem[rd_addr];
    pin_q    <= pin_mem[rd_addr];
    pin_ok_q <= pin_written[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_PIN;
      st_vld        <= 1'b0;
      key_count     <= '0;
      overflow      <= 1'b0;
      pin_length    <= CW'(kpcp_pkg::PIN_RESET_LENGTH);
      mode_reg      <= '0;
      ack_flag      <= 1'b0;
      mask_echo     <= 1'b1;
      pin_written   <= '0;
      result_valid  <= 1'b0;
      notify_remote <= 1'b0;
      acknowledged  <= 1'b0;
      alarm_mode    <= '0;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      st_vld        <= st_vld_next;
      key_count     <= key_count_next;
      overflow      <= overflow_next;
      pin_length    <= pin_length_next;
      mode_reg      <= mode_reg_next;
      ack_flag      <= ack_flag_next;
      mask_echo     <= mask_echo_next;
      result_valid  <= result_valid_next;
      notify_remote <= notify_next;
      if (pin_we) begin
        pin_written[wcnt[AW-1:0]] <= 1'b1;
      end
      if (load) begin
        alarm_mode   <= mode_reg_next;
        acknowledged <= ack_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx     <= rd_idx_next;
    proc_idx   <= proc_idx_next;
    mism       <= mism_next;
    value      <= value_next;
    ndig       <= ndig_next;
    wcnt       <= wcnt_next;
    echo_code  <= echo_code_next;
    echo_valid <= echo_valid_next;
    outcome    <= outcome_next;
  end

endmodule

// File: rtl/core/kpcp_checker.sv
`timescale 1ns / 1ps
// Port checker for the keypad PIN command parser, bound to the top level.
// Depends on kpcp_pkg and sees the top-level ports only.
module kpcp_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input kpcp_pkg::op_t      op,
  input kpcp_pkg::key_t     key_code,
  input logic               result_valid,
  input logic               result_ready,
  input kpcp_pkg::outcome_t outcome,
  input kpcp_pkg::mode_t    alarm_mode,
  input logic               acknowledged,
  input logic               notify_remote
);

  // A key other than hash is buffered and answered in the next cycle.
  a_key_buffered: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && op == kpcp_pkg::OP_KEY && key_code != kpcp_pkg::KEY_HASH
    |=> result_valid && outcome == kpcp_pkg::OC_BUFFERED)
    else $error("key transfer not answered as buffered");

  a_conf_acks: assert property (@(posedge clk) disable iff (rst)
    result_valid && outcome == kpcp_pkg::OC_REMOTE_CONF |-> acknowledged && !notify_remote)
    else $error("remote confirm without acknowledge");

  a_mode_set: assert property (@(posedge clk) disable iff (rst)
    result_valid && outcome == kpcp_pkg::OC_MODE_SET
    |-> !acknowledged && notify_remote && alarm_mode <= kpcp_pkg::MODE_KEYPAD_MAX)
    else $error("keypad mode set shows wrong flags or mode");

  a_notify_only_on_set: assert property (@(posedge clk) disable iff (rst)
    result_valid && notify_remote
    |-> outcome == kpcp_pkg::OC_MODE_SET || outcome == kpcp_pkg::OC_REMOTE_SET)
    else $error("notification without a mode change");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(outcome))
    else $error("stalled result changed");

endmodule

bind keypad_pin_command_parser kpcp_checker u_kpcp_checker (.*);

// File: sim/keypad_pin_command_parser_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for keypad_pin_command_parser: directed rows, then random
// keypad entries and remote operations; each result is checked against a typed row's
// values or a local predictor. Depends on kpcp_pkg and the parser RTL only.
module keypad_pin_command_parser_test;

  localparam int KEY_SLOTS    = 16;
  localparam int CMD_DIGITS   = 4;
  localparam int CMD_ALARM_OFF = 9;
  localparam kpcp_pkg::op_t OP_UNUSED   = 2'd3;
  localparam kpcp_pkg::key_t KEY_ODD_LO = 4'd12;
  localparam kpcp_pkg::key_t KEY_ODD_HI = 4'd15;

  localparam int RANDOM_ITEMS = 1120;
  localparam int CALM_FROM    = 500;
  localparam int CALM_TO      = 700;
  localparam int PAUSE_AT     = 900;
  localparam int HOLD_AFTER   = 250;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_CAP   = 40;

  typedef struct packed {
    kpcp_pkg::op_t   kind;
    kpcp_pkg::key_t  code;
    kpcp_pkg::mode_t mval;
  } item_t;

  typedef struct packed {
    kpcp_pkg::key_t     echo;
    logic               shown;
    kpcp_pkg::outcome_t verdict;
    kpcp_pkg::mode_t    mode;
    logic               ack;
    logic               notify;
  } result_t;

  typedef struct packed {
    item_t   stim;
    logic    typed;
    result_t want;
  } drow_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  kpcp_pkg::op_t      op = kpcp_pkg::OP_KEY;
  kpcp_pkg::key_t     key_code = kpcp_pkg::KEY_NONE;
  kpcp_pkg::mode_t    mode_value = 8'd0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  kpcp_pkg::key_t     echo_code;
  logic               echo_valid;
  kpcp_pkg::outcome_t outcome;
  kpcp_pkg::mode_t    alarm_mode;
  logic               acknowledged;
  logic               notify_remote;

  // Predictor state.
  kpcp_pkg::key_t  entry_keys [KEY_SLOTS];
  int              entry_len;
  bit              entry_overflow;
  kpcp_pkg::key_t  pin_digits [KEY_SLOTS];
  int              pin_len;
  kpcp_pkg::mode_t mode_now;
  bit              ack_now;
  bit              mask_now;

  result_t pending_results [$];
  item_t   entry_plan [$];
  drow_t   directed [$];

  int mismatches = 0;
  int results_taken = 0;
  int items_sent = 0;
  bit calm = 1'b0;
  bit hold_done = 1'b0;
  bit star_pins_ok = 1'b0;

  keypad_pin_command_parser #(
    .MAX_KEYS       (KEY_SLOTS),
    .MAX_CMD_DIGITS (CMD_DIGITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .op            (op),
    .key_code      (key_code),
    .mode_value    (mode_value),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .echo_code     (echo_code),
    .echo_valid    (echo_valid),
    .outcome       (outcome),
    .alarm_mode    (alarm_mode),
    .acknowledged  (acknowledged),
    .notify_remote (notify_remote)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= REPORT_CAP) begin
      $display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want,
               results_taken);
    end
  endtask

  // Evaluates the buffered entry when hash arrives.
  function automatic kpcp_pkg::outcome_t judge_entry(output logic notify);
    int star;
    int second;
    int ndig;
    int value;
    notify = 1'b0;
    if (entry_overflow) return kpcp_pkg::OC_FORMAT;
    star = entry_len;
    for (int i = entry_len - 1; i >= 0; i--) begin
      if (entry_keys[i] == kpcp_pkg::KEY_STAR) star = i;
    end
    if (star != pin_len) return kpcp_pkg::OC_WRONG_PIN;
    for (int i = 0; i < star; i++) begin
      if (entry_keys[i] != pin_digits[i]) return kpcp_pkg::OC_WRONG_PIN;
    end
    value = 0;
    ndig = 0;
    if (star < entry_len) begin
      for (int i = star + 1; i < entry_len && entry_keys[i] < kpcp_pkg::KEY_STAR; i++) begin
        ndig++;
        if (ndig <= CMD_DIGITS) value = value * 10 + int'(entry_keys[i]);
      end
      if (ndig > CMD_DIGITS) return kpcp_pkg::OC_INVALID;
    end
    case (value)
      kpcp_pkg::CMD_MODE_0, kpcp_pkg::CMD_MODE_1, kpcp_pkg::CMD_MODE_2,
      kpcp_pkg::CMD_MODE_3, kpcp_pkg::CMD_MODE_8: begin
        mode_now = kpcp_pkg::mode_t'(value);
        ack_now = 1'b0;
        notify = 1'b1;
        return kpcp_pkg::OC_MODE_SET;
      end
      kpcp_pkg::CMD_STATUS:  return kpcp_pkg::OC_INFO;
      kpcp_pkg::CMD_RESTART: return kpcp_pkg::OC_REBOOT;
      kpcp_pkg::CMD_EGG:     return kpcp_pkg::OC_EGG;
      kpcp_pkg::CMD_PIN_CHANGE: begin
        second = entry_len;
        for (int i = entry_len - 1; i > star; i--) begin
          if (entry_keys[i] == kpcp_pkg::KEY_STAR) second = i;
        end
        if (second >= entry_len) return kpcp_pkg::OC_FORMAT;
        pin_len = 0;
        for (int i = second + 1; i < entry_len; i++) begin
          pin_digits[pin_len] = entry_keys[i];
          pin_len++;
        end
        return kpcp_pkg::OC_PIN_CHANGED;
      end
      default: return kpcp_pkg::OC_INVALID;
    endcase
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t r;
    logic note;
    r = '0;
    note = 1'b0;
    r.verdict = kpcp_pkg::OC_INVALID;
    case (it.kind)
      kpcp_pkg::OP_KEY: begin
        r.shown = 1'b1;
        r.echo = mask_now ? kpcp_pkg::KEY_STAR : it.code;
        if (it.code == kpcp_pkg::KEY_STAR) mask_now = 1'b0;
        if (it.code == kpcp_pkg::KEY_HASH) begin
          r.verdict = judge_entry(note);
          entry_len = 0;
          entry_overflow = 1'b0;
          mask_now = 1'b1;
        end else begin
          r.verdict = kpcp_pkg::OC_BUFFERED;
          if (entry_len < KEY_SLOTS) begin
            entry_keys[entry_len] = it.code;
            entry_len++;
          end else begin
            entry_overflow = 1'b1;
          end
        end
      end
      kpcp_pkg::OP_REMOTE_SET: begin
        mode_now = it.mval;
        note = 1'b1;
        r.verdict = kpcp_pkg::OC_REMOTE_SET;
      end
      kpcp_pkg::OP_REMOTE_CONF: begin
        mode_now = it.mval;
        ack_now = 1'b1;
        r.verdict = kpcp_pkg::OC_REMOTE_CONF;
      end
      default: ;
    endcase
    r.mode = mode_now;
    r.ack = ack_now;
    r.notify = note;
    return r;
  endfunction

  // Offers one item, waits for its transfer, then records what should come back.
  task automatic send_item(item_t stim, logic typed, result_t typed_want);
    result_t want;
    if (!calm && $urandom_range(99) < 30) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    item_valid <= 1'b1;
    op <= stim.kind;
    key_code <= stim.code;
    mode_value <= stim.mval;
    do @(posedge clk); while (!item_ready);
    want = predict_result(stim);
    pending_results.push_back(typed ? typed_want : want);
  endtask

  function automatic drow_t plain_row(kpcp_pkg::op_t o, kpcp_pkg::key_t k,
                                      kpcp_pkg::mode_t m);
    drow_t d;
    d = '0;
    d.stim.kind = o;
    d.stim.code = k;
    d.stim.mval = m;
    return d;
  endfunction

  function automatic drow_t checked_row(kpcp_pkg::op_t o, kpcp_pkg::key_t k,
                                        kpcp_pkg::mode_t m, kpcp_pkg::key_t e, logic v,
                                        kpcp_pkg::outcome_t c, kpcp_pkg::mode_t md,
                                        logic a, logic n);
    drow_t d;
    d = plain_row(o, k, m);
    d.typed = 1'b1;
    d.want.echo = e;
    d.want.shown = v;
    d.want.verdict = c;
    d.want.mode = md;
    d.want.ack = a;
    d.want.notify = n;
    return d;
  endfunction

  function automatic void plan_key(kpcp_pkg::key_t k);
    item_t it;
    it.kind = kpcp_pkg::OP_KEY;
    it.code = k;
    it.mval = kpcp_pkg::mode_t'($urandom);
    entry_plan.push_back(it);
  endfunction

  function automatic kpcp_pkg::key_t any_digit();
    return kpcp_pkg::key_t'($urandom_range(9));
  endfunction

  // Any key code except hash, so the entry stays open.
  function automatic kpcp_pkg::key_t any_open_key();
    kpcp_pkg::key_t k;
    k = kpcp_pkg::key_t'($urandom_range(15));
    if (k == kpcp_pkg::KEY_HASH) k = kpcp_pkg::KEY_STAR;
    return k;
  endfunction

  function automatic int digits_of(int value);
    int n;
    n = 1;
    while (value >= 10) begin
      value = value / 10;
      n++;
    end
    return n;
  endfunction

  // Keys in a number as decimal digits, padded with leading zeros to the width.
  function automatic void plan_number(int value, int width);
    int div;
    div = 1;
    for (int i = 1; i < width; i++) div = div * 10;
    for (int i = 0; i < width; i++) begin
      plan_key(kpcp_pkg::key_t'((value / div) % 10));
      div = div / 10;
    end
  endfunction

  function automatic int any_mode_cmd();
    case ($urandom_range(4))
      0: return kpcp_pkg::CMD_MODE_0;
      1: return kpcp_pkg::CMD_MODE_1;
      2: return kpcp_pkg::CMD_MODE_2;
      3: return kpcp_pkg::CMD_MODE_3;
      default: return kpcp_pkg::CMD_MODE_8;
    endcase
  endfunction

  // A complete keypad entry: PIN (right or spoilt), optional star and command, hash.
  function automatic void plan_command(bit wrong_pin);
    int spot;
    int number;
    int width;
    spot = -1;
    if (wrong_pin && pin_len > 0 && $urandom_range(1) == 0) spot = $urandom_range(pin_len - 1);
    for (int i = 0; i < pin_len; i++) begin
      plan_key((i == spot) ? kpcp_pkg::key_t'((int'(pin_digits[i]) + 1) % 10)
                           : pin_digits[i]);
    end
    if (wrong_pin && spot < 0) plan_key(any_digit());
    case ($urandom_range(15))
      0: ;
      1: plan_key(kpcp_pkg::KEY_STAR);
      5: begin
        plan_key(kpcp_pkg::KEY_STAR);
        plan_number(kpcp_pkg::CMD_STATUS, digits_of(kpcp_pkg::CMD_STATUS));
      end
      6: begin
        plan_key(kpcp_pkg::KEY_STAR);
        plan_number(kpcp_pkg::CMD_RESTART, digits_of(kpcp_pkg::CMD_RESTART));
      end
      7: begin
        plan_key(kpcp_pkg::KEY_STAR);
        plan_number(kpcp_pkg::CMD_EGG, digits_of(kpcp_pkg::CMD_EGG));
      end
      8, 9: begin
        plan_key(kpcp_pkg::KEY_STAR);
        plan_number(kpcp_pkg::CMD_PIN_CHANGE, digits_of(kpcp_pkg::CMD_PIN_CHANGE));
        if ($urandom_range(9) != 0) begin
          plan_key(kpcp_pkg::KEY_STAR);
          width = $urandom_range(6);
          for (int i = 0; i < width; i++) begin
            // A star inside the PIN locks the keypad for good, so it only comes late.
            if (star_pins_ok && $urandom_range(3) == 0) plan_key(kpcp_pkg::KEY_STAR);
            else if ($urandom_range(6) == 0) plan_key(kpcp_pkg::key_t'($urandom_range(15, 12)));
            else plan_key(any_digit());
          end
        end
      end
      10: begin
        plan_key(kpcp_pkg::KEY_STAR);
        plan_number(CMD_ALARM_OFF, 1);
      end
      11: begin
        plan_key(kpcp_pkg::KEY_STAR);
        number = $urandom_range(9999);
        width = digits_of(number);
        plan_number(number, width + $urandom_range(CMD_DIGITS - width));
      end
      12: begin
        plan_key(kpcp_pkg::KEY_STAR);
        repeat ($urandom_range(7, CMD_DIGITS + 1)) plan_key(any_digit());
      end
      13: begin
        plan_key(kpcp_pkg::KEY_STAR);
        number = any_mode_cmd();
        plan_number(number, digits_of(number));
        if ($urandom_range(1) == 0) plan_key(kpcp_pkg::KEY_STAR);
        else plan_key(kpcp_pkg::key_t'($urandom_range(KEY_ODD_HI, KEY_ODD_LO)));
        if ($urandom_range(1) == 0) plan_key(any_digit());
      end
      default: begin
        plan_key(kpcp_pkg::KEY_STAR);
        number = any_mode_cmd();
        plan_number(number, digits_of(number) + $urandom_range(1));
      end
    endcase
    plan_key(kpcp_pkg::KEY_HASH);
  endfunction

  function automatic void plan_next();
    item_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      plan_command(1'b0);
    end else if (pick < 62) begin
      plan_command(1'b1);
    end else if (pick < 79) begin
      it.kind = (pick < 75) ? (($urandom_range(1) == 0) ? kpcp_pkg::OP_REMOTE_SET
                                                       : kpcp_pkg::OP_REMOTE_CONF)
                            : OP_UNUSED;
      it.code = kpcp_pkg::key_t'($urandom);
      if ($urandom_range(4) == 0) it.mval = ($urandom_range(1) == 0) ? 8'hFF : 8'h00;
      else it.mval = kpcp_pkg::mode_t'($urandom);
      entry_plan.push_back(it);
    end else if (pick < 87) begin
      // Fill the buffer to the brim or past it.
      repeat ($urandom_range(20, KEY_SLOTS)) plan_key(any_open_key());
      plan_key(kpcp_pkg::KEY_HASH);
    end else begin
      repeat ($urandom_range(6, 1)) plan_key(any_open_key());
      plan_key(kpcp_pkg::KEY_HASH);
    end
  endfunction

  // Result checker.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && result_ready) begin
      results_taken++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", int'(outcome), 0);
      end else begin
        want = pending_results.pop_front();
        if (echo_code !== want.echo) report_mismatch("echo_code", echo_code, want.echo);
        if (echo_valid !== want.shown) report_mismatch("echo_valid", echo_valid, want.shown);
        if (outcome !== want.verdict) report_mismatch("outcome", outcome, want.verdict);
        if (alarm_mode !== want.mode) report_mismatch("alarm_mode", alarm_mode, want.mode);
        if (acknowledged !== want.ack) report_mismatch("acknowledged", acknowledged, want.ack);
        if (notify_remote !== want.notify) begin
          report_mismatch("notify_remote", notify_remote, want.notify);
        end
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off so the input side stalls.
  initial begin : drive_result_ready
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!hold_done && results_taken >= HOLD_AFTER) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        result_ready <= calm || ($urandom_range(99) >= 30);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && item_ready) || (result_valid && result_ready)) quiet = 0;
      else quiet++;
    end
    $display("no transfer for %0d cycles", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    for (int i = 0; i < KEY_SLOTS; i++) begin
      entry_keys[i] = kpcp_pkg::KEY_NONE;
      pin_digits[i] = kpcp_pkg::KEY_NONE;
    end
    entry_len = 0;
    entry_overflow = 1'b0;
    pin_len = kpcp_pkg::PIN_RESET_LENGTH;
    mode_now = 8'd0;
    ack_now = 1'b0;
    mask_now = 1'b1;

    // Wrong PIN, remote ops at the mode extremes, and the unused op.
    directed.push_back(checked_row(kpcp_pkg::OP_KEY, 4'd1, 8'd0, kpcp_pkg::KEY_STAR, 1'b1,
                                   kpcp_pkg::OC_BUFFERED, 8'd0, 1'b0, 1'b0));
    directed.push_back(checked_row(kpcp_pkg::OP_KEY, kpcp_pkg::KEY_HASH, 8'd0,
                                   kpcp_pkg::KEY_STAR, 1'b1, kpcp_pkg::OC_WRONG_PIN, 8'd0,
                                   1'b0, 1'b0));
    directed.push_back(checked_row(kpcp_pkg::OP_REMOTE_SET, kpcp_pkg::KEY_NONE, 8'hFF,
                                   kpcp_pkg::KEY_NONE, 1'b0, kpcp_pkg::OC_REMOTE_SET, 8'hFF,
                                   1'b0, 1'b1));
    directed.push_back(checked_row(kpcp_pkg::OP_REMOTE_CONF, kpcp_pkg::KEY_NONE, 8'h00,
                                   kpcp_pkg::KEY_NONE, 1'b0, kpcp_pkg::OC_REMOTE_CONF, 8'h00,
                                   1'b1, 1'b0));
    directed.push_back(checked_row(OP_UNUSED, KEY_ODD_HI, 8'hFF,
                                   kpcp_pkg::KEY_NONE, 1'b0, kpcp_pkg::OC_INVALID, 8'h00,
                                   1'b1, 1'b0));
    // Reset PIN, then change it to an empty PIN.
    repeat (4) directed.push_back(plain_row(kpcp_pkg::OP_KEY, 4'd0, 8'd0));
    directed.push_back(plain_row(kpcp_pkg::OP_KEY, kpcp_pkg::KEY_STAR, 8'd0));
    repeat (2) directed.push_back(plain_row(kpcp_pkg::OP_KEY, 4'd9, 8'd0));
    directed.push_back(plain_row(kpcp_pkg::OP_KEY, kpcp_pkg::KEY_STAR, 8'd0));
    directed.push_back(checked_row(kpcp_pkg::OP_KEY, kpcp_pkg::KEY_HASH, 8'd0,
                                   kpcp_pkg::KEY_HASH, 1'b1, kpcp_pkg::OC_PIN_CHANGED, 8'd0,
                                   1'b1, 1'b0));
    // Nothing after the star selects mode zero.
    directed.push_back(plain_row(kpcp_pkg::OP_KEY, kpcp_pkg::KEY_STAR, 8'd0));
    directed.push_back(checked_row(kpcp_pkg::OP_KEY, kpcp_pkg::KEY_HASH, 8'd0,
                                   kpcp_pkg::KEY_HASH, 1'b1, kpcp_pkg::OC_MODE_SET, 8'd0,
                                   1'b0, 1'b1));
    // Disarm is refused.
    directed.push_back(plain_row(kpcp_pkg::OP_KEY, kpcp_pkg::KEY_STAR, 8'd0));
    directed.push_back(plain_row(kpcp_pkg::OP_KEY, 4'd9, 8'd0));
    directed.push_back(checked_row(kpcp_pkg::OP_KEY, kpcp_pkg::KEY_HASH, 8'd0,
                                   kpcp_pkg::KEY_HASH, 1'b1, kpcp_pkg::OC_INVALID, 8'd0,
                                   1'b0, 1'b0));
    // Reboot.
    directed.push_back(plain_row(kpcp_pkg::OP_KEY, kpcp_pkg::KEY_STAR, 8'd0));
    repeat (2) directed.push_back(plain_row(kpcp_pkg::OP_KEY, 4'd8, 8'd0));
    directed.push_back(plain_row(kpcp_pkg::OP_KEY, kpcp_pkg::KEY_HASH, 8'd0));
    // PIN change without a second star is a format error.
    directed.push_back(plain_row(kpcp_pkg::OP_KEY, kpcp_pkg::KEY_STAR, 8'd0));
    repeat (2) directed.push_back(plain_row(kpcp_pkg::OP_KEY, 4'd9, 8'd0));
    directed.push_back(checked_row(kpcp_pkg::OP_KEY, kpcp_pkg::KEY_HASH, 8'd0,
                                   kpcp_pkg::KEY_HASH, 1'b1, kpcp_pkg::OC_FORMAT, 8'd0,
                                   1'b0, 1'b0));
    // A non-digit key ends the number, so this selects mode eight.
    directed.push_back(plain_row(kpcp_pkg::OP_KEY, kpcp_pkg::KEY_STAR, 8'd0));
    directed.push_back(plain_row(kpcp_pkg::OP_KEY, 4'd8, 8'd0));
    directed.push_back(plain_row(kpcp_pkg::OP_KEY, KEY_ODD_HI, 8'd0));
    directed.push_back(plain_row(kpcp_pkg::OP_KEY, kpcp_pkg::KEY_HASH, 8'd0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_item(directed[i].stim, directed[i].typed, directed[i].want);

    while (items_sent < RANDOM_ITEMS || entry_plan.size() != 0) begin
      calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);
      star_pins_ok = (items_sent >= RANDOM_ITEMS - 60);
      if (entry_plan.size() == 0) plan_next();
      send_item(entry_plan.pop_front(), 1'b0, '0);
      items_sent++;
      if (items_sent == PAUSE_AT) begin
        // Let the block run dry before the next transfer.
        item_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
    end
    item_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/core/kpcp_pkg.sv
rtl/core/keypad_pin_command_parser.sv
rtl/core/kpcp_checker.sv
sim/keypad_pin_command_parser_test.sv
